// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked invariant and implication checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// invariant that holds at every edge out of reset
`define ASSERT_HOLDS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: invariant");
// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
`else
`define ASSERT_HOLDS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// ===== rtl/pimcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pimcl_pkg
// Widths, reset values, register codes and shared types of the PI current loop.
// ----------------------------------------------------------------------------
package pimcl_pkg;

	localparam int SUM_BITS_DEF  = 40;
	localparam int PWM_TOP       = 4095;
	localparam int LEVEL_BITS    = 12;
	localparam int ADC_BITS      = 12;
	localparam int GAIN_BITS     = 32;
	localparam int TARGET_BITS   = 15;
	localparam int CUR_BITS      = 16;
	localparam int CNT_BITS      = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [LEVEL_BITS-1:0] PWM_LEVEL = LEVEL_BITS'(PWM_TOP);

	localparam logic [GAIN_BITS-1:0]   RST_PROP_GAIN  = 32'd8589935;
	localparam logic [GAIN_BITS-1:0]   RST_INTEG_GAIN = 32'd4295;
	localparam logic [TARGET_BITS-1:0] RST_TARGET     = 15'd5000;
	localparam logic [ADC_BITS-1:0]    RST_POT_LOW    = 12'd1600;
	localparam logic [ADC_BITS-1:0]    RST_POT_HIGH   = 12'd3000;
	localparam logic [LEVEL_BITS-1:0]  RST_DUTY_LIMIT = 12'd3000;
	localparam logic [CNT_BITS-1:0]    RST_FLIP       = 16'd100;
	localparam logic [CNT_BITS-1:0]    RST_RUN_LEN    = 16'd400;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PROP_GAIN,
		REG_INTEG_GAIN,
		REG_TARGET,
		REG_POT_LOW,
		REG_POT_HIGH,
		REG_DUTY_LIMIT,
		REG_FLIP_PERIOD,
		REG_RUN_LENGTH
	} cfg_reg_t;

	// what the back end does with an item
	typedef enum logic [2:0] {
		KIND_HOLD,     // no control work, levels and integral kept
		KIND_START,    // run armed, integral cleared, levels kept
		KIND_CUTOFF,   // pot out of window, drive and integral zeroed
		KIND_CONTROL,  // PI step
		KIND_STOP      // run over, drive and integral zeroed
	} kind_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]   prop_gain;
		logic [GAIN_BITS-1:0]   integ_gain;
		logic [TARGET_BITS-1:0] target_current;
		logic [ADC_BITS-1:0]    pot_low_limit;
		logic [ADC_BITS-1:0]    pot_high_limit;
		logic [LEVEL_BITS-1:0]  duty_limit;
		logic [CNT_BITS-1:0]    flip_period;
		logic [CNT_BITS-1:0]    run_length;
	} cfg_t;

	typedef struct packed {
		kind_t                kind;
		logic [CUR_BITS-1:0]  desired;
		logic [CUR_BITS-1:0]  measured;
		logic                 logged;
		logic [CNT_BITS-1:0]  index;
		logic                 cutoff;
		logic                 run_active;
	} entry_t;

endpackage

// ===== rtl/pimcl_ifs.sv =====
// ----------------------------------------------------------------------------
// pimcl channel interfaces
// Valid/ready channels for tick items, result items and register writes.
// ----------------------------------------------------------------------------
interface pimcl_item_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic [pimcl_pkg::ADC_BITS-1:0]      pot_sample;
	logic signed [pimcl_pkg::CUR_BITS-1:0] shunt_sample;

	modport source(output valid, cmd, pot_sample, shunt_sample, input ready);
	modport sink(input valid, cmd, pot_sample, shunt_sample, output ready);
endinterface

interface pimcl_result_if;
	logic                                  valid;
	logic                                  ready;
	logic [pimcl_pkg::LEVEL_BITS-1:0]      fwd_level;
	logic [pimcl_pkg::LEVEL_BITS-1:0]      rev_level;
	logic signed [pimcl_pkg::CUR_BITS-1:0] desired_current;
	logic signed [pimcl_pkg::CUR_BITS-1:0] measured_current;
	logic                                  sample_logged;
	logic [pimcl_pkg::CNT_BITS-1:0]        sample_index;
	logic                                  cutoff_hit;
	logic                                  run_active;

	modport source(output valid, fwd_level, rev_level, desired_current, measured_current,
		sample_logged, sample_index, cutoff_hit, run_active, input ready);
	modport sink(input valid, fwd_level, rev_level, desired_current, measured_current,
		sample_logged, sample_index, cutoff_hit, run_active, output ready);
endinterface

interface pimcl_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [pimcl_pkg::CFG_IDX_BITS-1:0]   index;
	logic [pimcl_pkg::CFG_DATA_BITS-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/pimcl_front.sv =====
// ----------------------------------------------------------------------------
// pimcl_front
// Accepts tick and start items, runs the run/phase/setpoint sequencer and
// classifies each item for the back end.
// ----------------------------------------------------------------------------
module pimcl_front (
	input  logic              clk,
	input  logic              arst_n,
	pimcl_item_if.sink        item,
	input  pimcl_pkg::cfg_t   cfg,
	input  logic              q_full,
	output logic              push,
	output pimcl_pkg::entry_t entry
);

	logic                               active_q;
	logic [pimcl_pkg::CNT_BITS-1:0]     count_q;
	logic [pimcl_pkg::CNT_BITS-1:0]     phase_q;
	logic                               neg_q;

	logic                               active_d;
	logic [pimcl_pkg::CNT_BITS-1:0]     count_d;
	logic [pimcl_pkg::CNT_BITS-1:0]     phase_d;
	logic                               neg_d;

	logic                               in_window;
	logic                               neg_flip;
	logic [pimcl_pkg::CNT_BITS:0]       phase_inc;
	logic [pimcl_pkg::CUR_BITS-1:0]     target_s;

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	always_comb begin
		in_window = !(item.pot_sample < cfg.pot_low_limit ||
			item.pot_sample > cfg.pot_high_limit);
		neg_flip  = (phase_q == '0) ? !neg_q : neg_q;
		phase_inc = {1'b0, phase_q} + (pimcl_pkg::CNT_BITS+1)'(1);
		target_s  = {1'b0, cfg.target_current};

		active_d = active_q;
		count_d  = count_q;
		phase_d  = phase_q;
		neg_d    = neg_q;

		entry            = '0;
		entry.kind       = pimcl_pkg::KIND_HOLD;
		entry.run_active = active_q;

		if (item.cmd) begin
			if (!active_q) begin
				active_d         = 1'b1;
				count_d          = '0;
				phase_d          = '0;
				neg_d            = 1'b0;
				entry.kind       = pimcl_pkg::KIND_START;
				entry.run_active = 1'b1;
			end
		end else if (active_q) begin
			if (!in_window) begin
				entry.kind   = pimcl_pkg::KIND_CUTOFF;
				entry.cutoff = 1'b1;
			end else begin
				neg_d          = neg_flip;
				entry.desired  = neg_flip ? -target_s : target_s;
				entry.measured = item.shunt_sample;
				if (count_q < cfg.run_length) begin
					entry.kind   = pimcl_pkg::KIND_CONTROL;
					entry.logged = 1'b1;
					entry.index  = count_q;
					count_d      = count_q + pimcl_pkg::CNT_BITS'(1);
					phase_d      = (phase_inc >= {1'b0, cfg.flip_period}) ? '0 :
						phase_inc[pimcl_pkg::CNT_BITS-1:0];
				end else begin
					entry.kind       = pimcl_pkg::KIND_STOP;
					entry.run_active = 1'b0;
					active_d         = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			phase_q  <= '0;
			neg_q    <= 1'b0;
		end else if (push) begin
			active_q <= active_d;
			count_q  <= count_d;
			phase_q  <= phase_d;
			neg_q    <= neg_d;
		end
	end

endmodule

// ===== rtl/pimcl_queue.sv =====
// ----------------------------------------------------------------------------
// pimcl_queue
// Small FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module pimcl_queue #(
	parameter int DEPTH = pimcl_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pimcl_pkg::entry_t wr_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output pimcl_pkg::entry_t rd_data
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	pimcl_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/pimcl_back.sv =====
// ----------------------------------------------------------------------------
// pimcl_back
// PI datapath: integral update, split gain products, exact sum, truncation
// toward zero, clamp and bridge levels into the result register.
// ----------------------------------------------------------------------------
module pimcl_back #(
	parameter int SUM_BITS = pimcl_pkg::SUM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pimcl_pkg::cfg_t   cfg,
	input  logic              head_valid,
	input  pimcl_pkg::entry_t head,
	output logic              pop,
	pimcl_result_if.source    result
);

	localparam int GB       = pimcl_pkg::GAIN_BITS;
	localparam int LB       = pimcl_pkg::LEVEL_BITS;
	localparam int ERR_BITS = pimcl_pkg::CUR_BITS + 1;
	localparam int LO_BITS  = SUM_BITS / 2;
	localparam int HI_BITS  = SUM_BITS - LO_BITS;
	localparam int P_BITS   = GB + 1 + ERR_BITS;
	localparam int ILO_BITS = GB + LO_BITS;
	localparam int IHI_BITS = GB + 1 + HI_BITS;
	localparam int TOT_BITS = GB + SUM_BITS + 2;
	localparam int Q_BITS   = TOT_BITS - GB;

	localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

	logic                  en;
	logic [SUM_BITS-1:0]   sum_q;
	logic [LB-1:0]         fwd_q;
	logic [LB-1:0]         rev_q;

	// stage 1: error and integral
	logic                  v_s1;
	pimcl_pkg::entry_t     meta_s1;
	logic [ERR_BITS-1:0]   err_s1;
	logic [SUM_BITS-1:0]   sum_s1;
	// stage 2: partial products
	logic                  v_s2;
	pimcl_pkg::entry_t     meta_s2;
	logic signed [P_BITS-1:0]   p_s2;
	logic [ILO_BITS-1:0]        ilo_s2;
	logic signed [IHI_BITS-1:0] ihi_s2;
	// stage 3: exact sum
	logic                  v_s3;
	pimcl_pkg::entry_t     meta_s3;
	logic [TOT_BITS-1:0]   total_s3;
	// result register
	logic                  out_v_q;
	pimcl_pkg::entry_t     out_meta_q;
	logic [LB-1:0]         out_fwd_q;
	logic [LB-1:0]         out_rev_q;

	logic [ERR_BITS-1:0]   err;
	logic [SUM_BITS:0]     sum_ext;
	logic [SUM_BITS-1:0]   sum_sat;
	logic [SUM_BITS-1:0]   sum_d;

	logic [TOT_BITS-1:0]   p_ext;
	logic [TOT_BITS-1:0]   ilo_ext;
	logic [TOT_BITS-1:0]   ihi_ext;

	logic                  q_neg;
	logic                  frac_nz;
	logic [Q_BITS-1:0]     q_floor;
	logic [Q_BITS-1:0]     q_mag;
	logic [LB-1:0]         duty_mag;
	logic [LB-1:0]         fwd_d;
	logic [LB-1:0]         rev_d;

	assign en  = !out_v_q || result.ready;
	assign pop = en && head_valid;

	// integral update, saturating at the signed SUM_BITS range
	always_comb begin
		err = {head.desired[pimcl_pkg::CUR_BITS-1], head.desired} -
			{head.measured[pimcl_pkg::CUR_BITS-1], head.measured};
		sum_ext = {sum_q[SUM_BITS-1], sum_q} +
			{{(SUM_BITS+1-ERR_BITS){err[ERR_BITS-1]}}, err};
		if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
			sum_sat = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_ext[SUM_BITS-1:0];
		end
		unique case (head.kind)
			pimcl_pkg::KIND_CONTROL: sum_d = sum_sat;
			pimcl_pkg::KIND_HOLD:    sum_d = sum_q;
			default:                 sum_d = '0;
		endcase
	end

	always_comb begin
		p_ext   = {{(TOT_BITS-P_BITS){p_s2[P_BITS-1]}}, p_s2};
		ilo_ext = {{(TOT_BITS-ILO_BITS){1'b0}}, ilo_s2};
		ihi_ext = {{(TOT_BITS-IHI_BITS-LO_BITS){ihi_s2[IHI_BITS-1]}}, ihi_s2,
			{LO_BITS{1'b0}}};
	end

	// truncation toward zero: a negative value with a fraction rounds up
	always_comb begin
		q_floor = total_s3[TOT_BITS-1:GB];
		q_neg   = total_s3[TOT_BITS-1];
		frac_nz = |total_s3[GB-1:0];
		q_mag   = q_neg ? (~q_floor + Q_BITS'(!frac_nz)) : q_floor;
		duty_mag = (q_mag > {{(Q_BITS-LB){1'b0}}, cfg.duty_limit}) ? cfg.duty_limit :
			q_mag[LB-1:0];

		fwd_d = fwd_q;
		rev_d = rev_q;
		unique case (meta_s3.kind)
			pimcl_pkg::KIND_CONTROL: begin
				if (duty_mag == '0) begin
					fwd_d = '0;
					rev_d = '0;
				end else if (q_neg) begin
					fwd_d = pimcl_pkg::PWM_LEVEL;
					rev_d = duty_mag;
				end else begin
					fwd_d = duty_mag;
					rev_d = pimcl_pkg::PWM_LEVEL;
				end
			end
			pimcl_pkg::KIND_CUTOFF, pimcl_pkg::KIND_STOP: begin
				fwd_d = '0;
				rev_d = '0;
			end
			default: begin
				fwd_d = fwd_q;
				rev_d = rev_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			fwd_q   <= '0;
			rev_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= head_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
			if (head_valid) begin
				sum_q <= sum_d;
			end
			if (v_s3) begin
				fwd_q <= fwd_d;
				rev_q <= rev_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1    <= head;
			err_s1     <= err;
			sum_s1     <= sum_d;
			meta_s2    <= meta_s1;
			p_s2       <= $signed({1'b0, cfg.prop_gain}) * $signed(err_s1);
			ilo_s2     <= cfg.integ_gain * sum_s1[LO_BITS-1:0];
			ihi_s2     <= $signed({1'b0, cfg.integ_gain}) * $signed(sum_s1[SUM_BITS-1:LO_BITS]);
			meta_s3    <= meta_s2;
			total_s3   <= p_ext + ilo_ext + ihi_ext;
			out_meta_q <= meta_s3;
			out_fwd_q  <= fwd_d;
			out_rev_q  <= rev_d;
		end
	end

	assign result.valid            = out_v_q;
	assign result.fwd_level        = out_fwd_q;
	assign result.rev_level        = out_rev_q;
	assign result.desired_current  = out_meta_q.desired;
	assign result.measured_current = out_meta_q.measured;
	assign result.sample_logged    = out_meta_q.logged;
	assign result.sample_index     = out_meta_q.index;
	assign result.cutoff_hit       = out_meta_q.cutoff;
	assign result.run_active       = out_meta_q.run_active;

endmodule

// ===== rtl/pi_motor_current_loop.sv =====
// ----------------------------------------------------------------------------
// pi_motor_current_loop
// PI motor current controller with pot safety window and timed runs.
//
// Channels: item (sink) takes one beat per timer tick or start command;
// result (source) returns exactly one beat per item, in order, with the
// bridge levels, setpoint, measurement, sample count and run flags.
// cfg (sink) writes the eight control registers; it is always ready. The user must write
// it only while no item is in flight; the block itself does not enforce this.
// An accepted beat passes the queue, the error/integral, partial-product and exact-sum stages and the result register.
// Throughput: one item per cycle sustained while result.ready holds; the 32x(SUM_BITS) integral
// product is split in two halves in one stage, the exact sum takes the next.
// The front sequencer (run, phase, setpoint sign) and the back PI datapath
// are parted by a 4-entry queue: a result stall freezes the back pipeline
// and the queue absorbs up to 4 more beats before item.ready drops.
// Reset: registers return to their defaults, the run is idle, the integral
// and both bridge levels are zero, the queue is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pi_motor_current_loop #(
	parameter int SUM_BITS = pimcl_pkg::SUM_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pimcl_item_if.sink     item,
	pimcl_result_if.source result,
	pimcl_cfg_if.sink      cfg
);

	pimcl_pkg::cfg_t   cfg_q;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	pimcl_pkg::entry_t q_wr;
	pimcl_pkg::entry_t q_rd;

	// register port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= pimcl_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain     <= pimcl_pkg::RST_INTEG_GAIN;
			cfg_q.target_current <= pimcl_pkg::RST_TARGET;
			cfg_q.pot_low_limit  <= pimcl_pkg::RST_POT_LOW;
			cfg_q.pot_high_limit <= pimcl_pkg::RST_POT_HIGH;
			cfg_q.duty_limit     <= pimcl_pkg::RST_DUTY_LIMIT;
			cfg_q.flip_period    <= pimcl_pkg::RST_FLIP;
			cfg_q.run_length     <= pimcl_pkg::RST_RUN_LEN;
		end else if (cfg.valid) begin
			unique case (pimcl_pkg::cfg_reg_t'(cfg.index))
				pimcl_pkg::REG_PROP_GAIN:
					cfg_q.prop_gain <= cfg.data[pimcl_pkg::GAIN_BITS-1:0];
				pimcl_pkg::REG_INTEG_GAIN:
					cfg_q.integ_gain <= cfg.data[pimcl_pkg::GAIN_BITS-1:0];
				pimcl_pkg::REG_TARGET:
					cfg_q.target_current <= cfg.data[pimcl_pkg::TARGET_BITS-1:0];
				pimcl_pkg::REG_POT_LOW:
					cfg_q.pot_low_limit <= cfg.data[pimcl_pkg::ADC_BITS-1:0];
				pimcl_pkg::REG_POT_HIGH:
					cfg_q.pot_high_limit <= cfg.data[pimcl_pkg::ADC_BITS-1:0];
				pimcl_pkg::REG_DUTY_LIMIT:
					cfg_q.duty_limit <= cfg.data[pimcl_pkg::LEVEL_BITS-1:0];
				pimcl_pkg::REG_FLIP_PERIOD:
					cfg_q.flip_period <= cfg.data[pimcl_pkg::CNT_BITS-1:0];
				pimcl_pkg::REG_RUN_LENGTH:
					cfg_q.run_length <= cfg.data[pimcl_pkg::CNT_BITS-1:0];
			endcase
		end
	end

	// front: run sequencer and item classification
	pimcl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (q_push),
		.entry  (q_wr)
	);

	// decoupling queue
	pimcl_queue #(
		.DEPTH (pimcl_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (q_rd)
	);

	// back: PI datapath and result register
	pimcl_back #(
		.SUM_BITS (SUM_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (!q_empty),
		.head       (q_rd),
		.pop        (q_pop),
		.result     (result)
	);

	// drive must be off whenever no run is active
	`ASSERT_IMPLIES(a_idle_drive_off, result.valid && !result.run_active, result.fwd_level == '0 && result.rev_level == '0)
	// cutoff zeroes both bridge inputs
	`ASSERT_IMPLIES(a_cutoff_drive_off, result.valid && result.cutoff_hit, result.fwd_level == '0 && result.rev_level == '0)
	// a counted sample never ends the run
	`ASSERT_IMPLIES(a_logged_active, result.valid && result.sample_logged, result.run_active)
	// with both inputs driven, one of them sits at full level
	`ASSERT_IMPLIES(a_bridge_shape, result.valid && result.fwd_level != '0 && result.rev_level != '0, result.fwd_level == pimcl_pkg::PWM_LEVEL || result.rev_level == pimcl_pkg::PWM_LEVEL)

endmodule
